FILE: rtl/i2c_master_event_sequencer_assert.svh
// Assertion macros used by the sequencer engine.
`ifndef I2C_MASTER_EVENT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_EVENT_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

// Checks that a property holds at every clock edge outside reset.
`define I2C_MES_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2c_mes assertion failed");

// Checks that a condition never occurs outside reset.
`define I2C_MES_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("i2c_mes forbidden condition seen");

`else

`define I2C_MES_ASSERT(lbl, clk, rst_n, prop)
`define I2C_MES_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: rtl/i2c_mes_pkg.sv
// Shared types and constants of the I2C master event sequencer.
`default_nettype none

package i2c_mes_pkg;

    // Default saturation limit for transfer lengths
    localparam longint unsigned MAX_LENGTH_DEF = 64'd65535;

    // Operation codes
    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Transfer state codes as reported
    localparam logic [1:0] XS_READY = 2'd0;
    localparam logic [1:0] XS_WRITE = 2'd1;
    localparam logic [1:0] XS_READ  = 2'd2;

    // Notification codes
    localparam logic [1:0] NOTE_NONE       = 2'd0;
    localparam logic [1:0] NOTE_WRITE_DONE = 2'd1;
    localparam logic [1:0] NOTE_READ_DONE  = 2'd2;
    localparam logic [1:0] NOTE_STOP       = 2'd3;

    // Command or status event item
    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  slave_address;
        logic [15:0] transfer_length;
        logic        repeat_start;
        logic        flag_start_sent;
        logic        flag_address_sent;
        logic        flag_byte_finished;
        logic        flag_tx_empty;
        logic        flag_rx_not_empty;
        logic        flag_stop_detected;
        logic        flag_master_mode;
        logic [7:0]  byte_in;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [1:0] prior_state;
        logic       data_write_valid;
        logic [7:0] data_write;
        logic       start_request;
        logic       stop_request;
        logic       ack_level;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [1:0] notify_event;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/i2c_mes_if.sv
// Handshake channel interfaces of the sequencer.
`default_nettype none

// Command / status event channel
interface i2c_mes_cmd_if;
    logic               valid;
    logic               ready;
    i2c_mes_pkg::t_cmd  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Result channel
interface i2c_mes_res_if;
    logic               valid;
    logic               ready;
    i2c_mes_pkg::t_res  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Configuration write channel (ack_after_transfer)
interface i2c_mes_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/i2c_master_event_sequencer.sv
// Top level of the interrupt-driven I2C master transfer sequencer.
// Each command or status event passes an input register, combinational decision logic
// against the transfer state, and a result register: one result per item, and one
// item accepted per clock as long as the result side takes results. While a finished
// result waits, the input register holds one more item and then the input stalls;
// input ready follows result ready within the same cycle. The ack_after_transfer
// register may be written any time the block is idle and resets to 1.
`default_nettype none

module i2c_master_event_sequencer #(
    parameter longint unsigned MAX_LENGTH = i2c_mes_pkg::MAX_LENGTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    i2c_mes_cmd_if.sink   i_cmd,
    i2c_mes_cfg_if.sink   i_cfg,
    i2c_mes_res_if.source o_res
);

    logic              stg_valid;
    i2c_mes_pkg::t_cmd stg_cmd;
    logic              out_free;
    logic              fire;
    i2c_mes_pkg::t_res dec_res;

    // Configuration register is always writable
    assign i_cfg.ready = 1'b1;

    // Item moves from input register to result register
    assign fire = stg_valid && out_free;

    i2c_mes_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .i_cmd   (i_cmd.payload),
        .i_take  (fire),
        .o_valid (stg_valid),
        .o_cmd   (stg_cmd)
    );

    i2c_mes_engine #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_cmd     (stg_cmd),
        .i_cfg_we  (i_cfg.valid),
        .i_cfg_ack (i_cfg.data),
        .o_res     (dec_res)
    );

    i2c_mes_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (dec_res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

FILE: rtl/i2c_mes_in_stage.sv
// Input register holding one accepted command or event.
`default_nettype none

module i2c_mes_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire i2c_mes_pkg::t_cmd i_cmd,
    input  wire logic              i_take,
    output logic                   o_valid,
    output i2c_mes_pkg::t_cmd      o_cmd
);

    logic              r_valid;
    i2c_mes_pkg::t_cmd r_cmd;

    // Refill in the same cycle the held item moves on
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i2c_mes_engine.sv
// Transfer state and the per-item decision logic of the sequencer.
`default_nettype none

`include "i2c_master_event_sequencer_assert.svh"

module i2c_mes_engine #(
    parameter longint unsigned MAX_LENGTH = i2c_mes_pkg::MAX_LENGTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire i2c_mes_pkg::t_cmd i_cmd,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_ack,
    output i2c_mes_pkg::t_res      o_res
);

    // Counters never hold more than the saturation limit
    localparam int CNT_W = (MAX_LENGTH >= 64'd65535) ? 16 : $clog2(MAX_LENGTH + 64'd1);

    typedef enum logic [1:0] {
        ST_READY = i2c_mes_pkg::XS_READY,
        ST_WRITE = i2c_mes_pkg::XS_WRITE,
        ST_READ  = i2c_mes_pkg::XS_READ
    } t_xfer_state;

    t_xfer_state        r_state, n_state;
    logic [CNT_W-1:0]   r_send, n_send;
    logic [CNT_W-1:0]   r_recv, n_recv;
    logic [6:0]         r_addr, n_addr;
    logic               r_hold, n_hold;
    logic               r_evt_irq, n_evt_irq;
    logic               r_buf_irq, n_buf_irq;
    logic               r_ack, n_ack;
    logic               r_ack_cfg;
    i2c_mes_pkg::t_res  n_res;

    logic [CNT_W-1:0]   len_sat;
    logic [1:0]         done_note;
    logic               stop_note;

    // Length saturation for start commands
    always_comb begin
        if (64'(i_cmd.transfer_length) > MAX_LENGTH) begin
            len_sat = CNT_W'(MAX_LENGTH);
        end else begin
            len_sat = CNT_W'(i_cmd.transfer_length);
        end
    end

    // Handlers applied in order on the running state
    always_comb begin
        n_state   = r_state;
        n_send    = r_send;
        n_recv    = r_recv;
        n_addr    = r_addr;
        n_hold    = r_hold;
        n_evt_irq = r_evt_irq;
        n_buf_irq = r_buf_irq;
        n_ack     = r_ack;
        n_res     = '0;
        done_note = i2c_mes_pkg::NOTE_NONE;
        stop_note = 1'b0;
        n_res.prior_state = r_state;

        case (i_cmd.operation)
            i2c_mes_pkg::OP_WRITE, i2c_mes_pkg::OP_READ: begin
                if (r_state == ST_READY) begin
                    if (i_cmd.operation == i2c_mes_pkg::OP_WRITE) begin
                        n_send  = len_sat;
                        n_state = ST_WRITE;
                    end else begin
                        n_recv  = len_sat;
                        n_state = ST_READ;
                    end
                    n_addr              = i_cmd.slave_address;
                    n_hold              = i_cmd.repeat_start;
                    n_res.start_request = 1'b1;
                    n_evt_irq           = 1'b1;
                    n_buf_irq           = 1'b1;
                end
            end
            i2c_mes_pkg::OP_EVENT: begin
                // Start sent: address byte with direction bit
                if (r_evt_irq && i_cmd.flag_start_sent) begin
                    if (n_state == ST_READ) begin
                        n_res.data_write_valid = 1'b1;
                        n_res.data_write       = {r_addr, 1'b1};
                    end else if (n_state == ST_WRITE) begin
                        n_res.data_write_valid = 1'b1;
                        n_res.data_write       = {r_addr, 1'b0};
                    end
                end
                // Address sent on a one-byte read: NACK the only byte
                if (r_evt_irq && i_cmd.flag_address_sent && i_cmd.flag_master_mode &&
                    n_state == ST_READ && 32'(n_recv) == 32'd1) begin
                    n_ack = 1'b0;
                end
                // Byte finished with nothing left: close the write
                if (r_evt_irq && i_cmd.flag_byte_finished && n_state == ST_WRITE &&
                    i_cmd.flag_tx_empty && n_send == '0) begin
                    if (!r_hold) begin
                        n_res.stop_request = 1'b1;
                    end
                    n_evt_irq = 1'b0;
                    n_buf_irq = 1'b0;
                    n_state   = ST_READY;
                    n_send    = '0;
                    done_note = i2c_mes_pkg::NOTE_WRITE_DONE;
                end
                if (r_evt_irq && i_cmd.flag_stop_detected) begin
                    stop_note = 1'b1;
                end
                // Transmit empty: send the next byte
                if (r_evt_irq && r_buf_irq && i_cmd.flag_tx_empty && i_cmd.flag_master_mode &&
                    n_state == ST_WRITE && n_send != '0) begin
                    n_res.data_write_valid = 1'b1;
                    n_res.data_write       = i_cmd.byte_in;
                    n_send                 = n_send - CNT_W'(1);
                end
                // Receive not empty: store byte, close the read at zero
                if (r_evt_irq && r_buf_irq && i_cmd.flag_rx_not_empty &&
                    i_cmd.flag_master_mode && n_state == ST_READ) begin
                    if (n_recv != '0) begin
                        if (32'(n_recv) == 32'd2) begin
                            n_ack = 1'b0;
                        end
                        n_res.rx_valid = 1'b1;
                        n_res.rx_data  = i_cmd.byte_in;
                        n_recv         = n_recv - CNT_W'(1);
                    end
                    if (n_recv == '0) begin
                        if (!r_hold) begin
                            n_res.stop_request = 1'b1;
                        end
                        n_evt_irq = 1'b0;
                        n_buf_irq = 1'b0;
                        n_state   = ST_READY;
                        n_ack     = r_ack_cfg;
                        done_note = i2c_mes_pkg::NOTE_READ_DONE;
                    end
                end
            end
            default: begin
                // unused operation code: no change
            end
        endcase

        // A done notice outranks stop detection
        if (done_note != i2c_mes_pkg::NOTE_NONE) begin
            n_res.notify_event = done_note;
        end else if (stop_note) begin
            n_res.notify_event = i2c_mes_pkg::NOTE_STOP;
        end else begin
            n_res.notify_event = i2c_mes_pkg::NOTE_NONE;
        end
        n_res.ack_level = n_ack;
    end

    assign o_res = n_res;

    // State registers, updated once per transfer into the result stage; ack config on each config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_READY;
            r_send    <= '0;
            r_recv    <= '0;
            r_addr    <= '0;
            r_hold    <= 1'b0;
            r_evt_irq <= 1'b0;
            r_buf_irq <= 1'b0;
            r_ack     <= 1'b1;
            r_ack_cfg <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_ack_cfg <= i_cfg_ack;
            end
            if (i_fire) begin
                r_state   <= n_state;
                r_send    <= n_send;
                r_recv    <= n_recv;
                r_addr    <= n_addr;
                r_hold    <= n_hold;
                r_evt_irq <= n_evt_irq;
                r_buf_irq <= n_buf_irq;
                r_ack     <= n_ack;
            end
        end
    end

    // Interrupt enables track the busy state
    `I2C_MES_ASSERT(a_irq_busy, i_clk, i_rst_n, (r_evt_irq == r_buf_irq) && (r_evt_irq == (r_state != ST_READY)))
    // An accepted start leaves the sequencer busy
    `I2C_MES_ASSERT(a_start_busy, i_clk, i_rst_n, (i_fire && n_res.start_request) |=> (r_state != ST_READY))
    // A done notice returns the sequencer to ready
    `I2C_MES_ASSERT(a_done_ready, i_clk, i_rst_n, (i_fire && (n_res.notify_event == i2c_mes_pkg::NOTE_WRITE_DONE || n_res.notify_event == i2c_mes_pkg::NOTE_READ_DONE)) |=> (r_state == ST_READY))
    // Without a transfer the counters and the ack level hold
    `I2C_MES_ASSERT(a_hold_idle, i_clk, i_rst_n, !i_fire |=> ($stable(r_send) && $stable(r_recv) && $stable(r_ack)))
    // A start and a stop never leave in the same result
    `I2C_MES_ASSERT_NEVER(a_start_stop, i_clk, i_rst_n, i_fire && n_res.start_request && n_res.stop_request)

endmodule

`default_nettype wire

FILE: rtl/i2c_mes_out_stage.sv
// Result register driving the output channel.
`default_nettype none

module i2c_mes_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire i2c_mes_pkg::t_res i_res,
    output logic                   o_free,
    i2c_mes_res_if.source          o_res
);

    logic              r_valid;
    i2c_mes_pkg::t_res r_res;

    // Room when empty or the held result leaves this cycle
    assign o_free        = !r_valid || o_res.ready;
    assign o_res.valid   = r_valid;
    assign o_res.payload = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_i2c_master_event_sequencer.sv
// Self-checking testbench for the I2C master event sequencer: directed and random traffic.
`timescale 1ns / 100ps

module tb_i2c_master_event_sequencer;

    localparam int unsigned          LONG_STALL  = 300;
    localparam int unsigned          STALL_LIMIT = 3000;
    localparam longint unsigned      LEN_CAP     = i2c_mes_pkg::MAX_LENGTH_DEF;
    localparam logic [1:0]           OP_UNUSED   = 2'd3;

    // Status flag masks, in the order sb, addr, btf, txe, rxne, stop, msl
    localparam logic [6:0] EV_SB   = 7'b1000000;
    localparam logic [6:0] EV_ADDR = 7'b0100000;
    localparam logic [6:0] EV_BTF  = 7'b0010000;
    localparam logic [6:0] EV_TXE  = 7'b0001000;
    localparam logic [6:0] EV_RXNE = 7'b0000100;
    localparam logic [6:0] EV_STOP = 7'b0000010;
    localparam logic [6:0] EV_MSL  = 7'b0000001;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2c_mes_cmd_if cmd_ch ();
    i2c_mes_res_if res_ch ();
    i2c_mes_cfg_if cfg_ch ();

    i2c_master_event_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // Predicted sequencer state
    logic [1:0]  xfer_state;
    logic [15:0] tx_left;
    logic [15:0] rx_left;
    logic [6:0]  tgt_addr;
    logic        hold_bus;
    logic        evt_irq;
    logic        buf_irq;
    logic        ack_bit;
    logic        ack_cfg;

    i2c_mes_pkg::t_res due_responses[$];
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned burst_left;
    logic        stall_req;
    logic        long_stall;

    // Expected result of one item; updates the predicted state
    function automatic i2c_mes_pkg::t_res sequencer_response(input i2c_mes_pkg::t_cmd c);
        i2c_mes_pkg::t_res r;
        logic        evt_on;
        logic        buf_on;
        logic [1:0]  done_note;
        logic [1:0]  stop_note;
        logic [15:0] len;
        r = '0;
        r.prior_state = xfer_state;
        done_note = i2c_mes_pkg::NOTE_NONE;
        stop_note = i2c_mes_pkg::NOTE_NONE;
        len = (64'(c.transfer_length) > LEN_CAP) ? 16'(LEN_CAP) : c.transfer_length;
        if ((c.operation == i2c_mes_pkg::OP_WRITE || c.operation == i2c_mes_pkg::OP_READ) &&
            xfer_state == i2c_mes_pkg::XS_READY) begin
            if (c.operation == i2c_mes_pkg::OP_WRITE) begin
                tx_left = len;
                xfer_state = i2c_mes_pkg::XS_WRITE;
            end else begin
                rx_left = len;
                xfer_state = i2c_mes_pkg::XS_READ;
            end
            tgt_addr = c.slave_address;
            hold_bus = c.repeat_start;
            r.start_request = 1'b1;
            evt_irq = 1'b1;
            buf_irq = 1'b1;
        end else if (c.operation == i2c_mes_pkg::OP_EVENT) begin
            // enables as they stood when the event came in
            evt_on = evt_irq;
            buf_on = buf_irq;
            // start sent: address with direction bit
            if (evt_on && c.flag_start_sent && xfer_state != i2c_mes_pkg::XS_READY) begin
                r.data_write_valid = 1'b1;
                r.data_write = {tgt_addr, xfer_state == i2c_mes_pkg::XS_READ};
            end
            // address sent on a one-byte read: NACK the only byte
            if (evt_on && c.flag_address_sent && c.flag_master_mode &&
                xfer_state == i2c_mes_pkg::XS_READ && rx_left == 16'd1)
                ack_bit = 1'b0;
            // last byte out: close the write
            if (evt_on && c.flag_byte_finished && c.flag_tx_empty &&
                xfer_state == i2c_mes_pkg::XS_WRITE && tx_left == 16'd0) begin
                r.stop_request = !hold_bus;
                evt_irq = 1'b0;
                buf_irq = 1'b0;
                xfer_state = i2c_mes_pkg::XS_READY;
                done_note = i2c_mes_pkg::NOTE_WRITE_DONE;
            end
            if (evt_on && c.flag_stop_detected)
                stop_note = i2c_mes_pkg::NOTE_STOP;
            // next payload byte
            if (evt_on && buf_on && c.flag_tx_empty && c.flag_master_mode &&
                xfer_state == i2c_mes_pkg::XS_WRITE && tx_left != 16'd0) begin
                r.data_write_valid = 1'b1;
                r.data_write = c.byte_in;
                tx_left--;
            end
            // received byte, read closes as soon as the count hits zero
            if (evt_on && buf_on && c.flag_rx_not_empty && c.flag_master_mode &&
                xfer_state == i2c_mes_pkg::XS_READ) begin
                if (rx_left != 16'd0) begin
                    if (rx_left == 16'd2)
                        ack_bit = 1'b0;
                    r.rx_valid = 1'b1;
                    r.rx_data = c.byte_in;
                    rx_left--;
                end
                if (rx_left == 16'd0) begin
                    if (!hold_bus)
                        r.stop_request = 1'b1;
                    evt_irq = 1'b0;
                    buf_irq = 1'b0;
                    xfer_state = i2c_mes_pkg::XS_READY;
                    ack_bit = ack_cfg;
                    done_note = i2c_mes_pkg::NOTE_READ_DONE;
                end
            end
        end
        r.ack_level = ack_bit;
        r.notify_event = (done_note != i2c_mes_pkg::NOTE_NONE) ? done_note : stop_note;
        return r;
    endfunction

    function automatic string show_res(input i2c_mes_pkg::t_res r);
        return $sformatf("state=%0d wr=%0b/%02h start=%0b stop=%0b ack=%0b rx=%0b/%02h note=%0d",
                         r.prior_state, r.data_write_valid, r.data_write, r.start_request,
                         r.stop_request, r.ack_level, r.rx_valid, r.rx_data, r.notify_event);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", what);
    endfunction

    // Compare one accepted result with the oldest prediction
    function automatic void check_response(input i2c_mes_pkg::t_res got);
        i2c_mes_pkg::t_res want;
        string bad;
        if (due_responses.size() == 0) begin
            note_mismatch({"result with none pending: ", show_res(got)});
        end else begin
            want = due_responses.pop_front();
            bad = "";
            if (got.prior_state !== want.prior_state)           bad = {bad, " prior_state"};
            if (got.data_write_valid !== want.data_write_valid) bad = {bad, " data_write_valid"};
            if (got.data_write !== want.data_write)             bad = {bad, " data_write"};
            if (got.start_request !== want.start_request)       bad = {bad, " start_request"};
            if (got.stop_request !== want.stop_request)         bad = {bad, " stop_request"};
            if (got.ack_level !== want.ack_level)               bad = {bad, " ack_level"};
            if (got.rx_valid !== want.rx_valid)                 bad = {bad, " rx_valid"};
            if (got.rx_data !== want.rx_data)                   bad = {bad, " rx_data"};
            if (got.notify_event !== want.notify_event)         bad = {bad, " notify_event"};
            if (bad != "")
                note_mismatch($sformatf("result %0d:%s\n  expected %s\n  actual   %s",
                                        results_seen, bad, show_res(want), show_res(got)));
        end
        results_seen++;
    endfunction

    // Item builders; fields the item ignores get random values
    function automatic i2c_mes_pkg::t_cmd random_fill();
        logic [63:0] r64;
        r64 = {$urandom, $urandom};
        return r64[$bits(i2c_mes_pkg::t_cmd)-1:0];
    endfunction

    function automatic i2c_mes_pkg::t_cmd start_cmd(input logic [1:0] op,
                                                    input logic [6:0] addr,
                                                    input logic [15:0] len, input logic rs);
        i2c_mes_pkg::t_cmd c;
        c = random_fill();
        c.operation = op;
        c.slave_address = addr;
        c.transfer_length = len;
        c.repeat_start = rs;
        return c;
    endfunction

    function automatic i2c_mes_pkg::t_cmd status_event(input logic [6:0] flags,
                                                       input logic [7:0] data);
        i2c_mes_pkg::t_cmd c;
        c = random_fill();
        c.operation = i2c_mes_pkg::OP_EVENT;
        {c.flag_start_sent, c.flag_address_sent, c.flag_byte_finished, c.flag_tx_empty,
         c.flag_rx_not_empty, c.flag_stop_detected, c.flag_master_mode} = flags;
        c.byte_in = data;
        return c;
    endfunction

    // Fully random item; a start from ready gets a short length
    function automatic i2c_mes_pkg::t_cmd noise_item();
        i2c_mes_pkg::t_cmd c;
        c = random_fill();
        if (c.operation != i2c_mes_pkg::OP_EVENT && c.operation != OP_UNUSED &&
            xfer_state == i2c_mes_pkg::XS_READY)
            c.transfer_length = 16'($urandom_range(0, 6));
        return c;
    endfunction

    // Offer one item in bursts with random gaps; predict on transfer
    task automatic send_item(input i2c_mes_pkg::t_cmd c);
        if (burst_left == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= c;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        due_responses.push_back(sequencer_response(c));
        items_sent++;
    endtask

    // Drain all results, then allow for the pipeline
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_ack_cfg(input logic v);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        ack_cfg = v;
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 11) == 0)
            send_item(noise_item());
    endtask

    // Feed events until the predicted transfer has closed
    task automatic close_transfer();
        while (xfer_state != i2c_mes_pkg::XS_READY) begin
            if (xfer_state == i2c_mes_pkg::XS_READ)
                send_item(status_event(EV_RXNE | EV_MSL, 8'($urandom)));
            else if (tx_left != 16'd0)
                send_item(status_event(EV_TXE | EV_MSL, 8'($urandom)));
            else
                send_item(status_event(EV_BTF | EV_TXE | EV_MSL |
                                       (($urandom_range(0, 3) == 0) ? EV_STOP : 7'd0),
                                       8'($urandom)));
        end
    endtask

    // One well-formed transfer with random content and occasional noise
    task automatic run_transfer(input logic [1:0] op);
        int unsigned len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
        send_item(start_cmd(op, 7'($urandom), 16'(len), 1'($urandom)));
        maybe_noise();
        send_item(status_event(EV_SB | EV_MSL, 8'($urandom)));
        send_item(status_event(EV_ADDR | EV_MSL, 8'($urandom)));
        for (int unsigned i = 0; i < len; i++) begin
            maybe_noise();
            if (op == i2c_mes_pkg::OP_WRITE)
                send_item(status_event(EV_TXE | EV_MSL, 8'($urandom)));
            else
                send_item(status_event(EV_RXNE | EV_MSL |
                                       (($urandom_range(0, 7) == 0) ? EV_STOP : 7'd0),
                                       8'($urandom)));
        end
        close_transfer();
    endtask

    // Write: busy start, double data write, non-master event, done over stop
    task automatic test_write_transfer();
        send_item(start_cmd(i2c_mes_pkg::OP_WRITE, 7'h7F, 16'd3, 1'b0));
        send_item(start_cmd(i2c_mes_pkg::OP_READ, 7'h00, 16'hFFFF, 1'b1));
        send_item(status_event(EV_SB | EV_TXE | EV_MSL, 8'hFF));
        send_item(status_event(EV_ADDR | EV_MSL, 8'h00));
        send_item(status_event(EV_TXE | EV_MSL, 8'h00));
        send_item(status_event(EV_TXE, 8'h5A));
        send_item(status_event(EV_STOP, 8'h00));
        send_item(status_event(EV_TXE | EV_MSL, 8'hA5));
        send_item(status_event(EV_BTF | EV_TXE | EV_STOP | EV_MSL, 8'h00));
        send_item(status_event(7'h7F, 8'hFF));
        send_item(start_cmd(OP_UNUSED, 7'h7F, 16'hFFFF, 1'b1));
    endtask

    // Reads of one, two and zero bytes with ack restore from config
    task automatic test_read_transfers();
        write_ack_cfg(1'b0);
        send_item(start_cmd(i2c_mes_pkg::OP_READ, 7'h55, 16'd1, 1'b1));
        send_item(status_event(EV_SB | EV_MSL, 8'h00));
        send_item(status_event(EV_ADDR | EV_MSL, 8'h00));
        send_item(status_event(EV_RXNE | EV_MSL, 8'hC3));
        send_item(start_cmd(i2c_mes_pkg::OP_READ, 7'h00, 16'd2, 1'b0));
        send_item(status_event(EV_SB | EV_MSL, 8'h00));
        send_item(status_event(EV_ADDR | EV_MSL, 8'h00));
        send_item(status_event(EV_RXNE | EV_MSL, 8'h3C));
        send_item(start_cmd(OP_UNUSED, 7'h2A, 16'd5, 1'b0));
        send_item(status_event(EV_RXNE | EV_STOP | EV_MSL, 8'hFF));
        send_item(start_cmd(i2c_mes_pkg::OP_READ, 7'h01, 16'd0, 1'b0));
        send_item(status_event(EV_ADDR | EV_RXNE | EV_MSL, 8'h81));
        write_ack_cfg(1'b1);
    endtask

    // Zero-length write held on the bus closes on the first byte-finished event
    task automatic test_zero_length_write();
        send_item(start_cmd(i2c_mes_pkg::OP_WRITE, 7'h40, 16'd0, 1'b1));
        send_item(status_event(EV_BTF | EV_TXE, 8'h00));
    endtask

    // Receiver holds off for a long stretch while a long write keeps coming
    task automatic test_backpressure();
        wait_idle();
        stall_req <= 1'b1;
        @(posedge i_clk);
        stall_req <= 1'b0;
        send_item(start_cmd(i2c_mes_pkg::OP_WRITE, 7'h33, 16'd40, 1'b0));
        send_item(status_event(EV_SB | EV_MSL, 8'h00));
        send_item(status_event(EV_ADDR | EV_MSL, 8'h00));
        close_transfer();
    endtask

    task automatic test_random_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                run_transfer(i2c_mes_pkg::OP_WRITE);
            end else if (pick < 84) begin
                run_transfer(i2c_mes_pkg::OP_READ);
            end else begin
                repeat ($urandom_range(1, 5)) send_item(noise_item());
                close_transfer();
            end
        end
    endtask

    // Maximum length write; left open at the end of the run
    task automatic test_long_length();
        send_item(start_cmd(i2c_mes_pkg::OP_WRITE, 7'h2A, 16'hFFFF, 1'b0));
        send_item(status_event(EV_SB | EV_MSL, 8'h00));
        send_item(status_event(EV_ADDR | EV_MSL, 8'h00));
        repeat (20) send_item(status_event(EV_TXE | EV_MSL, 8'($urandom)));
    endtask

    // Result side: check each transfer, stall on a rotating random pattern
    initial begin
        logic [15:0] rdy_pat;
        int unsigned pat_left;
        logic        steady;
        res_ch.ready <= 1'b0;
        rdy_pat = 16'hFFFF;
        pat_left = 0;
        steady = 1'b1;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                check_response(res_ch.payload);
            if (pat_left == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                rdy_pat = 16'($urandom) | 16'h0001;
                pat_left = $urandom_range(20, 120);
            end else begin
                pat_left--;
            end
            rdy_pat = {rdy_pat[14:0], rdy_pat[15]};
            res_ch.ready <= i_rst_n && !long_stall && (steady || rdy_pat[0]);
        end
    end

    // Long receiver hold-off on request
    initial begin
        long_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                long_stall <= 1'b1;
                repeat (LONG_STALL) @(posedge i_clk);
                long_stall <= 1'b0;
            end
        end
    end

    // Watchdog: cycles with no transfer on any channel
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** i2c_master_event_sequencer: FAILED **");
        $finish;
    end

    // Test sequence
    initial begin
        cmd_ch.valid <= 1'b0;
        cmd_ch.payload <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= 1'b0;
        stall_req <= 1'b0;
        i_rst_n <= 1'b0;
        xfer_state = i2c_mes_pkg::XS_READY;
        tx_left = '0;
        rx_left = '0;
        tgt_addr = '0;
        hold_bus = 1'b0;
        evt_irq = 1'b0;
        buf_irq = 1'b0;
        ack_bit = 1'b1;
        ack_cfg = 1'b1;
        items_sent = 0;
        results_seen = 0;
        mismatches = 0;
        burst_left = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_write_transfer();
        test_read_transfers();
        test_zero_length_write();
        test_backpressure();
        write_ack_cfg(1'b0);
        test_random_traffic(400);
        write_ack_cfg(1'b1);
        test_random_traffic(400);
        write_ack_cfg(1'b0);
        test_random_traffic(400);
        write_ack_cfg(1'b1);
        test_random_traffic(400);
        test_long_length();

        cmd_ch.valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("** i2c_master_event_sequencer: PASSED **");
        else
            $display("** i2c_master_event_sequencer: FAILED **");
        $finish;
    end

endmodule
